// ----- rtl/core/qrcp_pkg.sv -----
// ----------------------------------------------------------------------------
// qrcp_pkg
// Shared types, constants and the microcode program of the Q16.16 reciprocal.
// ----------------------------------------------------------------------------
package qrcp_pkg;

    localparam int unsigned STEP_W = 4;

    localparam logic [31:0] Q_ONE         = 32'h0001_0000;
    localparam logic [31:0] Q_ROOT2       = 32'h0001_6A09;
    localparam logic [31:0] SEED_ADJ_LOW  = 32'h0000_047B;
    localparam logic [31:0] SEED_ADJ_HIGH = 32'h0000_032B;
    localparam logic [31:0] UMAX_RESULT   = 32'hFFFF_FFFF;
    localparam logic [31:0] SMAX_RESULT   = 32'h7FFF_FFFF;
    localparam logic [4:0]  EXP_BIAS      = 5'd16;

    typedef logic [STEP_W-1:0] step_t;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LZ,
        OP_NORM,
        OP_SEED1,
        OP_SEED2,
        OP_DENORM,
        OP_MUL_YY,
        OP_MUL_XT,
        OP_UPDATE,
        OP_DONE
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_ZERO,
        COND_NOREF,
        COND_ITER_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } dp_ctrl_t;

    typedef struct packed {
        logic zero;
        logic noref;
        logic iter_more;
    } dp_status_t;

    localparam step_t S_LZ     = 4'd0;
    localparam step_t S_NORM   = 4'd1;
    localparam step_t S_SEED1  = 4'd2;
    localparam step_t S_SEED2  = 4'd3;
    localparam step_t S_DENORM = 4'd4;
    localparam step_t S_MUL_YY = 4'd5;
    localparam step_t S_MUL_XT = 4'd6;
    localparam step_t S_UPDATE = 4'd7;
    localparam step_t S_DONE   = 4'd8;

    // microcode ROM
    function automatic ucode_t ucode_rom(input step_t addr);
        ucode_t w;
        w = '{op: OP_DONE, cond: COND_NONE, target: S_DONE};
        case (addr)
            S_LZ:     w = '{op: OP_LZ,     cond: COND_ZERO,      target: S_DONE};
            S_NORM:   w = '{op: OP_NORM,   cond: COND_NONE,      target: S_DONE};
            S_SEED1:  w = '{op: OP_SEED1,  cond: COND_NONE,      target: S_DONE};
            S_SEED2:  w = '{op: OP_SEED2,  cond: COND_NONE,      target: S_DONE};
            S_DENORM: w = '{op: OP_DENORM, cond: COND_NOREF,     target: S_DONE};
            S_MUL_YY: w = '{op: OP_MUL_YY, cond: COND_NONE,      target: S_DONE};
            S_MUL_XT: w = '{op: OP_MUL_XT, cond: COND_NONE,      target: S_DONE};
            S_UPDATE: w = '{op: OP_UPDATE, cond: COND_ITER_MORE, target: S_MUL_YY};
            S_DONE:   w = '{op: OP_DONE,   cond: COND_NONE,      target: S_DONE};
            default:  w = '{op: OP_DONE,   cond: COND_NONE,      target: S_DONE};
        endcase
        return w;
    endfunction

    // leading-one position of a nonzero word
    function automatic logic [4:0] lead_pos(input logic [31:0] v);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i])
            begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

endpackage

// ----- rtl/core/qrcp_seq.sv -----
// ----------------------------------------------------------------------------
// qrcp_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module qrcp_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  qrcp_pkg::dp_status_t status,
    output qrcp_pkg::dp_ctrl_t   ctrl,
    output logic                 busy
);
    import qrcp_pkg::*;

    logic   busy_reg, busy_next;
    step_t  step_reg, step_next;
    ucode_t word;
    logic   jump;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        case (word.cond)
            COND_NONE:      jump = 1'b0;
            COND_ZERO:      jump = status.zero;
            COND_NOREF:     jump = status.noref;
            COND_ITER_MORE: jump = status.iter_more;
            default:        jump = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                step_next = S_LZ;
            end
        end
        else if (word.op == OP_DONE)
        begin
            busy_next = 1'b0;
        end
        else
        begin
            step_next = jump ? word.target : step_reg + step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= S_LZ;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    assign ctrl.load = start && !busy_reg;
    assign ctrl.op   = busy_reg ? word.op : OP_NOP;
    assign busy      = busy_reg;

endmodule

// ----- rtl/core/qrcp_dp.sv -----
// ----------------------------------------------------------------------------
// qrcp_dp
// Reciprocal datapath: operand/seed registers, one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module qrcp_dp #(
    parameter int NEWTON_STEPS  = 2,
    parameter int NO_REFINE_EXP = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qrcp_pkg::dp_ctrl_t   ctrl,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic [31:0]          value_in,
    output qrcp_pkg::dp_status_t status,
    output logic [31:0]          recip_out,
    output logic                 div_zero,
    output logic                 done
);
    import qrcp_pkg::*;

    logic        smode_reg;
    logic        done_reg, done_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] t_reg, t_next;
    logic [4:0]  pos_reg, pos_next;
    logic [4:0]  mag_reg, mag_next;
    logic        epos_reg, epos_next;
    logic        hi_reg, hi_next;
    logic        dz_reg, dz_next;
    logic        neg_reg, neg_next;
    logic [2:0]  iter_reg, iter_next;
    logic [31:0] res_reg, res_next;
    logic        dzo_reg, dzo_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    assign mul_a = (ctrl.op == OP_MUL_XT) ? x_reg : y_reg;
    assign mul_b = (ctrl.op == OP_MUL_XT) ? t_reg : y_reg;
    assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

    assign status.zero      = dz_reg;
    assign status.noref     = (NEWTON_STEPS == 0) || (32'(mag_reg) >= 32'(NO_REFINE_EXP));
    assign status.iter_more = (32'(iter_reg) + 32'd1) != 32'(NEWTON_STEPS);

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        t_next    = t_reg;
        pos_next  = pos_reg;
        mag_next  = mag_reg;
        epos_next = epos_reg;
        hi_next   = hi_reg;
        dz_next   = dz_reg;
        neg_next  = neg_reg;
        iter_next = iter_reg;
        res_next  = res_reg;
        dzo_next  = dzo_reg;
        done_next = 1'b0;

        if (ctrl.load)
        begin
            neg_next = smode_reg && value_in[31];
            x_next   = (smode_reg && value_in[31]) ? (32'd0 - value_in) : value_in;
            dz_next  = (value_in == 32'd0);
        end

        case (ctrl.op)
            OP_NOP: ;
            OP_LZ:
            begin
                pos_next = lead_pos(x_reg);
            end
            OP_NORM:
            begin
                epos_next = pos_reg > EXP_BIAS;
                mag_next  = (pos_reg > EXP_BIAS) ? (pos_reg - EXP_BIAS) : (EXP_BIAS - pos_reg);
                y_next    = (pos_reg > EXP_BIAS) ? (x_reg >> (pos_reg - EXP_BIAS))
                                                 : (x_reg << (EXP_BIAS - pos_reg));
            end
            OP_SEED1:
            begin
                // hi_reg is not yet valid here, pick the segment directly
                hi_next = y_reg > Q_ROOT2;
                if (y_reg > Q_ROOT2)
                begin
                    y_next = ((y_reg - Q_ROOT2) << 5) + ((y_reg - Q_ROOT2) << 3)
                           + ((y_reg - Q_ROOT2) << 2) + (y_reg - Q_ROOT2);
                end
                else
                begin
                    y_next = ((y_reg - Q_ONE) << 5) + ((y_reg - Q_ONE) << 3)
                           + ((y_reg - Q_ONE) << 2) + (y_reg - Q_ONE);
                end
            end
            OP_SEED2:
            begin
                y_next = hi_reg ? ((Q_ROOT2 >> 1) - (y_reg >> 7) - SEED_ADJ_HIGH)
                                : (Q_ONE - (y_reg >> 6) - SEED_ADJ_LOW);
            end
            OP_DENORM:
            begin
                y_next    = epos_reg ? (y_reg >> mag_reg) : (y_reg << mag_reg);
                iter_next = '0;
            end
            OP_MUL_YY, OP_MUL_XT:
            begin
                t_next = prod[47:16];
            end
            OP_UPDATE:
            begin
                y_next    = (y_reg << 1) - t_reg;
                iter_next = iter_reg + 3'd1;
            end
            OP_DONE:
            begin
                done_next = 1'b1;
                dzo_next  = dz_reg;
                if (dz_reg)
                begin
                    res_next = smode_reg ? SMAX_RESULT : UMAX_RESULT;
                end
                else
                begin
                    res_next = neg_reg ? (32'd0 - y_reg) : y_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smode_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                smode_reg <= cfg_wdata;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        t_reg    <= t_next;
        pos_reg  <= pos_next;
        mag_reg  <= mag_next;
        epos_reg <= epos_next;
        hi_reg   <= hi_next;
        dz_reg   <= dz_next;
        neg_reg  <= neg_next;
        iter_reg <= iter_next;
        res_reg  <= res_next;
        dzo_reg  <= dzo_next;
    end

    assign recip_out = res_reg;
    assign div_zero  = dzo_reg;
    assign done      = done_reg;

endmodule

// ----- rtl/core/q16_16_reciprocal.sv -----
// ----------------------------------------------------------------------------
// q16_16_reciprocal
// Q16.16 reciprocal: linear seed plus Newton refinement, microcoded control.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction starts at a clock edge with start high and busy low; value_in
//   is sampled at that edge. busy stays high while the sequencer runs.
//   The result appears on recip_out/div_zero for exactly one cycle with done
//   high; the receiver cannot stall and must take it then.
//   A zero operand jumps from the leading-zero step to done; refinement
//   is skipped when |exponent| >= NO_REFINE_EXP or NEWTON_STEPS is 0.
//   One transaction at a time; a new start is taken in the cycle done is shown.
//   The microcode program runs each Newton step as two products through the
//   single shared 32x32 multiplier and one update. The user writes signed_mode
//   with cfg_we/cfg_wdata only while busy is low; the block has no check.
//   Reset clears busy, done and signed_mode (unsigned).
// ----------------------------------------------------------------------------
module q16_16_reciprocal #(
    parameter int NEWTON_STEPS  = 2,
    parameter int NO_REFINE_EXP = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value_in,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output logic [31:0] recip_out,
    output logic        div_zero,
    output logic        done
);
    import qrcp_pkg::*;

    dp_ctrl_t   ctrl;
    dp_status_t status;

    qrcp_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    qrcp_dp #(
        .NEWTON_STEPS  (NEWTON_STEPS),
        .NO_REFINE_EXP (NO_REFINE_EXP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .value_in  (value_in),
        .status    (status),
        .recip_out (recip_out),
        .div_zero  (div_zero),
        .done      (done)
    );

endmodule

// ----- rtl/core/qrcp_checker.sv -----
// ----------------------------------------------------------------------------
// qrcp_checker
// Port-level checks of the reciprocal's command handshake and result strobe.
// ----------------------------------------------------------------------------
module qrcp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] recip_out,
    input  logic        div_zero,
    input  logic        done
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done shown while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy fell without a result");

    a_zero_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_zero |-> (recip_out == 32'hFFFF_FFFF) || (recip_out == 32'h7FFF_FFFF))
        else $error("zero operand without maximum result");

endmodule

bind q16_16_reciprocal qrcp_checker u_qrcp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .recip_out (recip_out),
    .div_zero  (div_zero),
    .done      (done)
);
